### design/rbe_pkg.sv
// Package for the run-length Brainfuck executor: sizes, action codes and payload types.
package rbe_pkg;

   // Tape size; must be a power of two so head arithmetic wraps by truncation
   localparam int TAPE_CELLS    = 32768;
   localparam int HEAD_W        = $clog2(TAPE_CELLS);
   localparam int PROGRAM_WORDS = 4096;
   localparam int PC_W          = 13;
   localparam int NEXT_W        = 17;

   typedef enum logic [3:0] {
      ACT_EXIT  = 4'd0,
      ACT_LEFT  = 4'd1,
      ACT_RIGHT = 4'd2,
      ACT_INC   = 4'd3,
      ACT_DEC   = 4'd4,
      ACT_IN    = 4'd5,
      ACT_OUT   = 4'd6,
      ACT_JZ    = 4'd7,
      ACT_JNZ   = 4'd8
   } act_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [15:0] operand;
      logic [7:0]  in_byte;
   } req_type;

   typedef struct packed {
      logic [12:0] fetch_index;
      logic        halted;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic [15:0] out_repeat;
   } rsp_type;

   // Clearing sequencer status
   typedef struct packed {
      logic              busy;
      logic [HEAD_W-1:0] addr;
   } clr_type;

   // Execute stage side effects
   typedef struct packed {
      logic            wr_en;
      logic [7:0]      wr_data;
      logic [PC_W-1:0] pc;
      logic            stopped;
   } exec_type;

endpackage

### design/rbe_tape_ram.sv
// Tape memory: one write port, one read port with registered read data.
module rbe_tape_ram
   import rbe_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [HEAD_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [HEAD_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [TAPE_CELLS];
   logic [7:0] rd_data_ff;

   // Write the addressed cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the addressed cell, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rbe_clear.sv
// Tape clearing sequencer: sweeps every cell to zero after reset.
module rbe_clear
   import rbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   output clr_type clr
);

   localparam logic [HEAD_W-1:0] LAST_ADDR = HEAD_W'(TAPE_CELLS - 1);

   logic              busy_ff;
   logic              busy_in;
   logic [HEAD_W-1:0] addr_ff;
   logic [HEAD_W-1:0] addr_in;

   // Advance one cell a cycle, drop busy after the last cell
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + HEAD_W'(1);
         if (addr_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clr.busy = busy_ff;
   assign clr.addr = addr_ff;

endmodule

### design/rbe_exec.sv
// Execute stage: applies one instruction to the current cell and program counter.
module rbe_exec
   import rbe_pkg::*;
(
   input  req_type         req,
   input  logic [7:0]      cur_byte,
   input  logic [PC_W-1:0] pc,
   input  logic            stopped,
   output exec_type        ex,
   output rsp_type         rsp
);

   localparam logic [NEXT_W-1:0] PROG_END = NEXT_W'(PROGRAM_WORDS);

   logic [NEXT_W-1:0] seq_next;
   logic [NEXT_W-1:0] jmp_next;
   logic [NEXT_W-1:0] nxt;
   logic              emit;
   logic              halt;

   assign seq_next = NEXT_W'(pc) + NEXT_W'(1);
   assign jmp_next = NEXT_W'(req.operand) + NEXT_W'(1);

   always_comb begin
      ex.wr_en        = 1'b0;
      ex.wr_data      = cur_byte;
      ex.pc           = pc;
      ex.stopped      = stopped;
      rsp.fetch_index = pc;
      rsp.halted      = stopped;
      rsp.out_valid   = 1'b0;
      rsp.out_byte    = '0;
      rsp.out_repeat  = '0;
      nxt             = seq_next;
      emit            = 1'b0;
      halt            = 1'b0;

      if (!stopped) begin
         // Decode the action
         case (req.action)
            ACT_LEFT, ACT_RIGHT: begin
               // head moves at accept time
            end
            ACT_INC: begin
               ex.wr_en   = 1'b1;
               ex.wr_data = cur_byte + req.operand[7:0];
            end
            ACT_DEC: begin
               ex.wr_en   = 1'b1;
               ex.wr_data = cur_byte - req.operand[7:0];
            end
            ACT_IN: begin
               ex.wr_en   = (req.operand != 16'd0);
               ex.wr_data = req.in_byte;
            end
            ACT_OUT: begin
               emit = (req.operand != 16'd0);
            end
            ACT_JZ: begin
               if (cur_byte == 8'd0) begin
                  nxt = jmp_next;
               end
            end
            ACT_JNZ: begin
               if (cur_byte != 8'd0) begin
                  nxt = jmp_next;
               end
            end
            default: begin
               halt = 1'b1;
            end
         endcase

         // Advance the program counter; stop on exit, or saturate at the program end and stop
         if (halt) begin
            ex.stopped = 1'b1;
         end else if (nxt >= PROG_END) begin
            ex.pc      = PC_W'(PROGRAM_WORDS);
            ex.stopped = 1'b1;
         end else begin
            ex.pc = nxt[PC_W-1:0];
         end

         rsp.fetch_index = ex.pc;
         rsp.halted      = ex.stopped;
         rsp.out_valid   = emit;
         rsp.out_byte    = emit ? cur_byte : 8'd0;
         rsp.out_repeat  = emit ? req.operand : 16'd0;
      end
   end

endmodule

### design/rle_brainfuck_executor_unit.sv
// Top level of the run-length Brainfuck executor: head, tape pipeline and result register.
// Pipeline: an accepted request passes the tape read register, then the result register.
// Throughput: one request per cycle unless rsp_stall holds the result register, set by
// the single tape read-modify-write per instruction; the last written cell is forwarded
// to the following read.
// Reset: synchronous; afterwards a clearing pass zeroes every tape cell (TAPE_CELLS),
// during which req_stall is high.
module rle_brainfuck_executor_unit
   import rbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   clr_type           clr;
   exec_type          ex;
   rsp_type           ex_rsp;

   logic              acc;
   logic              b_adv;
   logic [7:0]        rd_data;
   logic [7:0]        cur_byte;
   logic [HEAD_W-1:0] shift_amt;

   logic              ram_wr_en;
   logic [HEAD_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;

   logic              b_vld_ff;
   req_type           b_req_ff;
   logic [HEAD_W-1:0] b_addr_ff;
   logic [HEAD_W-1:0] head_ff;
   logic [HEAD_W-1:0] head_in;
   logic [PC_W-1:0]   pc_ff;
   logic              stopped_ff;
   logic              fwd_vld_ff;
   logic [HEAD_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   rbe_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   // Handshake: execute stage moves on when the result register is free
   assign b_adv     = b_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr.busy || (b_vld_ff && !b_adv);
   assign acc       = req_valid && !req_stall;

   // Head moves at accept time; the tape size is a power of two
   assign shift_amt = HEAD_W'(req_data.operand);

   always_comb begin
      head_in = head_ff;
      case (req_data.action)
         ACT_LEFT:  head_in = head_ff - shift_amt;
         ACT_RIGHT: head_in = head_ff + shift_amt;
         default:   head_in = head_ff;
      endcase
   end

   // Tape write port: clearing pass first, then execute stage write-back
   always_comb begin
      if (clr.busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr.addr;
         ram_wr_data = 8'd0;
      end else begin
         ram_wr_en   = b_adv && ex.wr_en;
         ram_wr_addr = b_addr_ff;
         ram_wr_data = ex.wr_data;
      end
   end

   rbe_tape_ram u_tape (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (acc),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Forward the last written cell over a read of the same address
   assign cur_byte = (fwd_vld_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff : rd_data;

   rbe_exec u_exec (
      .req      (b_req_ff),
      .cur_byte (cur_byte),
      .pc       (pc_ff),
      .stopped  (stopped_ff),
      .ex       (ex),
      .rsp      (ex_rsp)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         head_ff      <= '0;
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (acc) begin
            b_vld_ff <= 1'b1;
            head_ff  <= head_in;
         end else if (b_adv) begin
            b_vld_ff <= 1'b0;
         end
         if (b_adv) begin
            pc_ff        <= ex.pc;
            stopped_ff   <= ex.stopped;
            rsp_valid_ff <= 1'b1;
            if (ex.wr_en) begin
               fwd_vld_ff <= 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         b_req_ff  <= req_data;
         b_addr_ff <= head_ff;
      end
      if (b_adv) begin
         rsp_data_ff <= ex_rsp;
         if (ex.wr_en) begin
            fwd_addr_ff <= b_addr_ff;
            fwd_data_ff <= ex.wr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No request enters while the tape is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr.busy |-> req_stall)
      else $error("request accepted during tape clearing");

   // No instruction write-back while the clearing pass runs
   a_no_exec_write: assert property (@(posedge clock) disable iff (reset)
      clr.busy |-> !b_vld_ff)
      else $error("execute stage active during tape clearing");

   // A stopped program stays stopped
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stopped flag cleared without reset");

   // Results issued while stopped report halted and emit nothing
   a_stopped_rsp: assert property (@(posedge clock) disable iff (reset)
      (b_adv && stopped_ff) |=> (rsp_data_ff.halted && !rsp_data_ff.out_valid))
      else $error("result after stop not marked halted");

endmodule
